/* src/lie_pkg.sv */
// package: shared constants, types and state encoding for the lagrange evaluator
package lie_pkg;
    localparam int MaxNodes  = 16;
    localparam int FracBits  = 16;
    localparam int IdxW      = $clog2(MaxNodes);
    localparam int DataW     = 32;
    // quotient numerator (33 bits) shifted by FracBits, unsigned magnitude
    localparam int NumW      = DataW + 1 + FracBits;
    localparam int DenW      = DataW + 1;
    localparam int QuoW      = NumW;
    localparam int DivCntW   = $clog2(NumW + 1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [0:0] REG_DEGREE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP_RD,
        ST_DUP_CMP,
        ST_K_RD,
        ST_I_RD,
        ST_DIV,
        ST_MUL,
        ST_TERM,
        ST_SUM,
        ST_OUT
    } t_state;

    // divider control between sequencer and divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

/* src/lie_if.sv */
// interfaces: input and output item channels
interface lie_in_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  node_index;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] eval_x;
    modport source (output valid, func, node_index, node_x, node_y, eval_x, input ready);
    modport sink   (input valid, func, node_index, node_x, node_y, eval_x, output ready);
endinterface

interface lie_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic signed [31:0] value;
    logic        duplicate_node;
    logic        saturated;
    modport source (output valid, value, duplicate_node, saturated, input ready);
    modport sink   (input valid, value, duplicate_node, saturated, output ready);
endinterface

/* src/lie_node_ram.sv */
// node store: x and y memories, one write port and two read ports, registered reads
module lie_node_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lie_pkg::IdxW-1:0]      i_waddr,
    input  logic signed [31:0]            i_wx,
    input  logic signed [31:0]            i_wy,
    input  logic [lie_pkg::IdxW-1:0]      i_raddr_a,
    input  logic [lie_pkg::IdxW-1:0]      i_raddr_b,
    output logic signed [31:0]            o_xa,
    output logic signed [31:0]            o_ya,
    output logic signed [31:0]            o_xb
);
    logic signed [31:0] r_mem_x [lie_pkg::MaxNodes];
    logic signed [31:0] r_mem_y [lie_pkg::MaxNodes];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
        o_xa <= r_mem_x[i_raddr_a];
        o_ya <= r_mem_y[i_raddr_a];
        o_xb <= r_mem_x[i_raddr_b];
    end
endmodule

/* src/lie_divider.sv */
// divider: signed fixed-point quotient, restoring radix-2, rounded and clipped
module lie_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [32:0]         i_num,
    input  logic signed [32:0]         i_den,
    output lie_pkg::t_div_ctl          o_ctl,
    output logic signed [31:0]         o_quo,
    output logic                       o_sat
);
    localparam int NW = lie_pkg::NumW;
    localparam int DW = lie_pkg::DenW;

    logic [NW-1:0]                 r_rem_num, n_rem_num;
    logic [DW:0]                   r_rem, n_rem;
    logic [DW-1:0]                 r_den;
    logic [NW-1:0]                 r_quo, n_quo;
    logic                          r_neg;
    logic [lie_pkg::DivCntW-1:0]   r_cnt;
    logic                          r_busy, r_done;
    logic [DW-1:0]                 w_an, w_ad;
    logic [DW:0]                   w_trial;
    logic [NW:0]                   w_q_rnd;
    logic signed [NW+1:0]          w_q_signed;

    assign w_an = i_num[32] ? DW'(-i_num) : DW'(i_num);
    assign w_ad = i_den[32] ? DW'(-i_den) : DW'(i_den);

    always_comb begin
        w_trial   = {r_rem[DW-1:0], r_rem_num[NW-1]};
        n_rem_num = {r_rem_num[NW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo = {r_quo[NW-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lie_pkg::DivCntW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lie_pkg::DivCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem_num <= {w_an, {lie_pkg::FracBits{1'b0}}};
            r_rem     <= '0;
            r_quo     <= '0;
            r_den     <= w_ad;
            r_neg     <= i_num[32] ^ i_den[32];
        end else if (r_busy) begin
            r_rem_num <= n_rem_num;
            r_rem     <= n_rem;
            r_quo     <= n_quo;
        end
    end

    // round to nearest, ties away: add one when 2*rem >= den
    always_comb begin
        w_q_rnd    = {1'b0, r_quo} + ((r_rem << 1) >= {1'b0, r_den} ? 1'b1 : 1'b0);
        w_q_signed = r_neg ? -$signed({1'b0, w_q_rnd}) : $signed({1'b0, w_q_rnd});
        o_sat = 1'b0;
        if (w_q_signed > $signed((NW+2)'(32'sh7fffffff))) begin
            o_quo = 32'sh7fffffff;
            o_sat = 1'b1;
        end else if (w_q_signed < -$signed((NW+2)'(33'h080000000))) begin
            o_quo = 32'sh80000000;
            o_sat = 1'b1;
        end else begin
            o_quo = w_q_signed[31:0];
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
endmodule

/* src/lagrange_interpolation_eval_unit.sv */
// top level: lagrange polynomial evaluator with node store, divider and sequencer
//
// usage
// - input channel (lie_in_if): func 0 loads node_x/node_y at node_index,
//   func 1 evaluates the polynomial through nodes 0..degree at eval_x
// - output channel (lie_out_if): one item per evaluate item, none per load
// - apb port: register 0 is degree (4 bits, reset 1), byte address 0
// - a load item is written to the node store when accepted; ready stays high
// - an evaluate item with degree n (0 runs as 1) first runs the duplicate scan
//   (a read and a compare per pair, cut short at the first match), then per k
//   a read, and per i != k a start step, the serial divider (49 quotient bits,
//   then done), a multiply and an address step; a final result step follows
// - ready returns as the result enters the output register
// - the result waits in an output register until taken while the next item is
//   accepted; the sequencer holds in its result step, and the input with it,
//   only while an older result is still waiting
// - reset clears the control state and sets degree to 1; node memories are
//   undefined until loaded
module lagrange_interpolation_eval_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lie_in_if.sink      in_ch,
    lie_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = lie_pkg::IdxW;

    lie_pkg::t_state      r_state, n_state;
    logic [3:0]           r_degree;
    logic [IW-1:0]        r_n, r_k, r_i;
    logic [IW-1:0]        n_k, n_i;
    logic signed [31:0]   r_xe;
    logic signed [31:0]   r_yk;
    logic signed [31:0]   r_p, r_q;
    logic signed [35:0]   r_acc;
    logic                 r_sat, r_dup;
    logic signed [31:0]   r_value;
    logic                 r_odup, r_osat;
    logic                 r_ovalid;
    logic                 w_out_free;

    // node store, port a at k, port b at i
    logic                 w_we;
    logic signed [31:0]   w_xa, w_ya, w_xb;
    lie_node_ram u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (in_ch.node_index[IW-1:0]),
        .i_wx     (in_ch.node_x),
        .i_wy     (in_ch.node_y),
        .i_raddr_a(r_k),
        .i_raddr_b(r_i),
        .o_xa     (w_xa),
        .o_ya     (w_ya),
        .o_xb     (w_xb)
    );

    // divider, operands from the registered eval_x and the node store read
    lie_pkg::t_div_ctl    w_div;
    logic                 w_div_start;
    logic signed [31:0]   w_quo;
    logic                 w_quo_sat;
    lie_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (33'(r_xe) - 33'(w_xb)),
        .i_den  (33'(w_xa) - 33'(w_xb)),
        .o_ctl  (w_div),
        .o_quo  (w_quo),
        .o_sat  (w_quo_sat)
    );

    // apb: always ready, degree register at index 0
    logic w_cfg_wr;
    logic w_reg_degree;
    assign pready       = 1'b1;
    assign w_reg_degree = (paddr == 2'(lie_pkg::REG_DEGREE * 4));
    assign w_cfg_wr     = psel && penable && pwrite && w_reg_degree;
    assign prdata       = w_reg_degree ? {28'd0, r_degree} : 32'd0;

    assign in_ch.ready = (r_state == lie_pkg::ST_IDLE);
    assign w_we = in_ch.valid && in_ch.ready && (in_ch.func == lie_pkg::FUNC_LOAD);

    // output register free now or emptied at this edge
    assign w_out_free = !r_ovalid || out_ch.ready;

    assign out_ch.valid          = r_ovalid;
    assign out_ch.value          = r_value;
    assign out_ch.duplicate_node = r_odup;
    assign out_ch.saturated      = r_osat;

    // multiply and round-shift, clipped
    logic signed [63:0]   w_prod, w_term_prod;
    logic signed [63:0]   w_pr_sh, w_tm_sh;
    assign w_prod      = 64'(r_p) * 64'(r_q);
    assign w_term_prod = 64'(r_yk) * 64'(r_p);
    assign w_pr_sh = (w_prod + 64'(1 << (lie_pkg::FracBits - 1))) >>> lie_pkg::FracBits;
    assign w_tm_sh = (w_term_prod + 64'(1 << (lie_pkg::FracBits - 1))) >>> lie_pkg::FracBits;

    function automatic logic signed [32:0] clip(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       clip = {1'b1, 32'sh7fffffff};
        else if (v < -64'sd2147483648) clip = {1'b1, 32'sh80000000};
        else                           clip = {1'b0, v[31:0]};
    endfunction

    logic signed [32:0] w_pc, w_tc, w_sc;
    logic signed [63:0] w_acc_ext;
    assign w_pc = clip(w_pr_sh);
    assign w_tc = clip(w_tm_sh);
    assign w_acc_ext = 64'(r_acc);
    assign w_sc = clip(w_acc_ext);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_i         = r_i;
        w_div_start = 1'b0;
        case (r_state)
            lie_pkg::ST_IDLE: begin
                if (in_ch.valid && in_ch.ready && in_ch.func == lie_pkg::FUNC_EVAL) begin
                    n_state = lie_pkg::ST_DUP_RD;
                    n_k = '0;
                    n_i = IW'(1);
                end
            end
            lie_pkg::ST_DUP_RD: n_state = lie_pkg::ST_DUP_CMP;
            lie_pkg::ST_DUP_CMP: begin
                if (w_xa == w_xb) begin
                    n_state = lie_pkg::ST_OUT;
                end else if (r_i != r_n) begin
                    n_i = r_i + 1'b1;
                    n_state = lie_pkg::ST_DUP_RD;
                end else if (r_k + 1'b1 != r_n) begin
                    n_k = r_k + 1'b1;
                    n_i = r_k + IW'(2);
                    n_state = lie_pkg::ST_DUP_RD;
                end else begin
                    n_k = '0;
                    n_i = IW'(1);
                    n_state = lie_pkg::ST_K_RD;
                end
            end
            lie_pkg::ST_K_RD: begin
                n_state = lie_pkg::ST_I_RD;
            end
            lie_pkg::ST_I_RD: begin
                w_div_start = 1'b1;
                n_state = lie_pkg::ST_DIV;
            end
            lie_pkg::ST_DIV: if (w_div.done) n_state = lie_pkg::ST_MUL;
            lie_pkg::ST_MUL: begin
                if (r_i == r_n || (r_i + 1'b1 == r_k && r_k == r_n)) begin
                    n_state = lie_pkg::ST_TERM;
                end else begin
                    n_i = (r_i + 1'b1 == r_k) ? r_i + IW'(2) : r_i + 1'b1;
                    n_state = lie_pkg::ST_SUM;
                end
            end
            lie_pkg::ST_SUM: n_state = lie_pkg::ST_I_RD;
            lie_pkg::ST_TERM: begin
                if (r_k == r_n) begin
                    n_state = lie_pkg::ST_OUT;
                end else begin
                    n_k = r_k + 1'b1;
                    n_i = '0;
                    n_state = lie_pkg::ST_K_RD;
                end
            end
            lie_pkg::ST_OUT: if (w_out_free) n_state = lie_pkg::ST_IDLE;
            default: n_state = lie_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lie_pkg::ST_IDLE;
            r_degree <= 4'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_degree <= pwdata[3:0];
            if (r_state == lie_pkg::ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_k <= n_k;
        r_i <= n_i;
        if (r_state == lie_pkg::ST_IDLE) begin
            r_xe  <= in_ch.eval_x;
            r_n   <= (r_degree == 4'd0) ? IW'(1) : r_degree;
            r_sat <= 1'b0;
            r_dup <= 1'b0;
            r_acc <= '0;
        end
        if (r_state == lie_pkg::ST_DUP_CMP && w_xa == w_xb) begin
            r_dup <= 1'b1;
        end
        if (r_state == lie_pkg::ST_K_RD) begin
            r_p <= 32'sd1 <<< lie_pkg::FracBits;
        end
        if (r_state == lie_pkg::ST_I_RD) begin
            r_yk <= w_ya;
        end
        if (r_state == lie_pkg::ST_DIV && w_div.done) begin
            r_q <= w_quo;
            if (w_quo_sat) r_sat <= 1'b1;
        end
        if (r_state == lie_pkg::ST_MUL) begin
            r_p <= w_pc[31:0];
            if (w_pc[32]) r_sat <= 1'b1;
        end
        if (r_state == lie_pkg::ST_TERM) begin
            r_acc <= r_acc + 36'($signed(w_tc[31:0]));
            if (w_tc[32]) r_sat <= 1'b1;
        end
        if (r_state == lie_pkg::ST_OUT && w_out_free) begin
            if (r_dup) begin
                r_value <= '0;
                r_odup  <= 1'b1;
                r_osat  <= 1'b0;
            end else begin
                r_value <= w_sc[31:0];
                r_odup  <= 1'b0;
                r_osat  <= r_sat | w_sc[32];
            end
        end
    end

    // result appears only after the sequencer finishes
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == lie_pkg::ST_OUT) else $error("stray result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lie_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div.busy) else $error("divider restarted");
endmodule
